// ----- hw/rtl/egc_pkg.sv -----
`default_nettype none

package egc_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned KW    = $clog2(DataW);
  localparam int unsigned PcW   = 4;

  typedef logic [DataW-1:0] data_t;
  typedef logic [KW-1:0]    kcnt_t;
  typedef logic [PcW-1:0]   pc_t;

  typedef enum logic [2:0] {
    OpNop,
    OpCopyB,
    OpHalveBoth,
    OpHalveA,
    OpHalveB,
    OpSub,
    OpShlA,
    OpOut
  } op_e;

  typedef enum logic [3:0] {
    CondAlways,
    CondAZero,
    CondBZero,
    CondBothEven,
    CondAEven,
    CondBEvenNz,
    CondBNonzero,
    CondKNonzero,
    CondOutBlocked
  } cond_e;

  typedef struct packed {
    cond_e cond;
    op_e   op;
    pc_t   target;
  } ucode_t;

  localparam pc_t PcAZero    = pc_t'(0);
  localparam pc_t PcBZero    = pc_t'(1);
  localparam pc_t PcBothEven = pc_t'(2);
  localparam pc_t PcAEven    = pc_t'(3);
  localparam pc_t PcBEven    = pc_t'(4);
  localparam pc_t PcSub      = pc_t'(5);
  localparam pc_t PcScale    = pc_t'(6);
  localparam pc_t PcWait     = pc_t'(7);
  localparam pc_t PcOut      = pc_t'(8);

  // when cond holds: run op and jump to target, else fall through to pc + 1
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    begin
      unique case (pc)
        PcAZero:    w = '{cond: CondAZero,      op: OpCopyB,     target: PcWait};
        PcBZero:    w = '{cond: CondBZero,      op: OpNop,       target: PcWait};
        PcBothEven: w = '{cond: CondBothEven,   op: OpHalveBoth, target: PcBothEven};
        PcAEven:    w = '{cond: CondAEven,      op: OpHalveA,    target: PcAEven};
        PcBEven:    w = '{cond: CondBEvenNz,    op: OpHalveB,    target: PcBEven};
        PcSub:      w = '{cond: CondBNonzero,   op: OpSub,       target: PcBEven};
        PcScale:    w = '{cond: CondKNonzero,   op: OpShlA,      target: PcScale};
        PcWait:     w = '{cond: CondOutBlocked, op: OpNop,       target: PcWait};
        PcOut:      w = '{cond: CondAlways,     op: OpOut,       target: PcAZero};
        default:    w = '{cond: CondAlways,     op: OpOut,       target: PcAZero};
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/egc_if.sv -----
`default_nettype none

interface egc_in_if import egc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value_a;
  data_t value_b;

  modport source (output valid, output value_a, output value_b, input ready);
  modport sink   (input valid, input value_a, input value_b, output ready);
endinterface

interface egc_out_if import egc_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t divisor;
  logic  coprime;

  modport source (output valid, output divisor, output coprime, input ready);
  modport sink   (input valid, input divisor, input coprime, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/euclid_gcd_coprime.sv -----
// Greatest common divisor of two signed 64-bit operands, with a coprime flag.
//
// in_i carries value_a and value_b (two's complement); out_o returns divisor
// (unsigned, gcd of the magnitudes, 0 to 2^63) and coprime (divisor == 1).
// Both channels use valid/ready; an item moves when both are high.
//
// One item is worked on at a time: in_i.ready is high while the sequencer is
// idle. A small microcode program drives a binary reduction datapath (halve,
// subtract, rescale), one control word per cycle, 64-bit subtract per step.
// The time from accept to out_o.valid depends on the operand bits. The next
// item is accepted in the cycle after the result is loaded into the output
// register, so that register holds a result while the next item runs.
//
// If the receiver stalls, the finished result waits in the output register;
// a following item runs to completion and then waits in the sequencer until
// the register is free. Reset clears the sequencer and drops out_o.valid;
// nothing is kept between items.
`default_nettype none

module euclid_gcd_coprime import egc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  egc_in_if.sink    in_i,
  egc_out_if.source out_o
);

  logic   busy_q, busy_d;
  pc_t    pc_q, pc_d;
  data_t  a_q, a_d;
  data_t  b_q, b_d;
  kcnt_t  k_q, k_d;
  logic   out_valid_q, out_valid_d;
  data_t  div_q, div_d;
  logic   cop_q, cop_d;

  ucode_t       uw;
  logic         take;
  logic         in_acc;
  logic [DataW:0] diff_ba;
  data_t        diff_ab;
  data_t        mag_a, mag_b;

  assign in_i.ready    = ~busy_q;
  assign in_acc        = in_i.valid & ~busy_q;
  assign out_o.valid   = out_valid_q;
  assign out_o.divisor = div_q;
  assign out_o.coprime = cop_q;

  assign mag_a   = in_i.value_a[DataW-1] ? (~in_i.value_a + data_t'(1)) : in_i.value_a;
  assign mag_b   = in_i.value_b[DataW-1] ? (~in_i.value_b + data_t'(1)) : in_i.value_b;
  assign diff_ba = {1'b0, b_q} - {1'b0, a_q};
  assign diff_ab = a_q - b_q;

  assign uw = ucode_rom(pc_q);

  always_comb begin
    unique case (uw.cond)
      CondAlways:     take = 1'b1;
      CondAZero:      take = (a_q == '0);
      CondBZero:      take = (b_q == '0);
      CondBothEven:   take = ~a_q[0] & ~b_q[0];
      CondAEven:      take = ~a_q[0];
      CondBEvenNz:    take = ~b_q[0] & (b_q != '0);
      CondBNonzero:   take = (b_q != '0);
      CondKNonzero:   take = (k_q != '0);
      CondOutBlocked: take = out_valid_q & ~out_o.ready;
      default:        take = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    div_d       = div_q;
    cop_d       = cop_q;
    if (in_acc) begin
      busy_d = 1'b1;
      pc_d   = PcAZero;
      a_d    = mag_a;
      b_d    = mag_b;
      k_d    = '0;
    end else if (busy_q) begin
      if (take) begin
        pc_d = uw.target;
        unique case (uw.op)
          OpNop:       ;
          OpCopyB:     a_d = b_q;
          OpHalveBoth: begin
            a_d = {1'b0, a_q[DataW-1:1]};
            b_d = {1'b0, b_q[DataW-1:1]};
            k_d = k_q + kcnt_t'(1);
          end
          OpHalveA:    a_d = {1'b0, a_q[DataW-1:1]};
          OpHalveB:    b_d = {1'b0, b_q[DataW-1:1]};
          OpSub: begin
            if (diff_ba[DataW]) begin
              a_d = b_q;
              b_d = diff_ab;
            end else begin
              b_d = diff_ba[DataW-1:0];
            end
          end
          OpShlA: begin
            a_d = {a_q[DataW-2:0], 1'b0};
            k_d = k_q - kcnt_t'(1);
          end
          OpOut: begin
            busy_d      = 1'b0;
            out_valid_d = 1'b1;
            div_d       = a_q;
            cop_d       = (a_q == data_t'(1));
          end
          default:     ;
        endcase
      end else begin
        pc_d = pc_q + pc_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= PcAZero;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    div_q <= div_d;
    cop_q <= cop_d;
  end

  a_in_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (busy_q && pc_q == PcAZero))
    else $error("accepted item did not start the program");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(pc_q) == PcOut && !busy_q))
    else $error("result appeared outside the output step");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= PcOut))
    else $error("step counter left the program");

  a_coprime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.coprime == (out_o.divisor == data_t'(1))))
    else $error("coprime flag does not match divisor");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
  import egc_pkg::*;

  typedef struct {
    data_t divisor;
    logic  coprime;
  } gcd_result_t;

  localparam data_t MostNeg = {1'b1, {(DataW-1){1'b0}}};
  localparam data_t MostPos = {1'b0, {(DataW-1){1'b1}}};
  localparam int unsigned DrainCycles = 300;
  localparam longint unsigned LimitCycles = 1_200_000;

  logic clk;
  logic rst_n;

  egc_in_if  gcd_in();
  egc_out_if gcd_out();

  euclid_gcd_coprime dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (gcd_in.sink),
    .out_o  (gcd_out.source)
  );

  gcd_result_t expected_gcd_q[$];
  int unsigned error_count;
  int unsigned pairs_sent;
  int unsigned results_seen;
  int unsigned coprime_seen;
  int unsigned zero_seen;
  bit          idle_on;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LimitCycles * 20);
    $display("testbench failed");
    $finish;
  end

  function automatic data_t magnitude_of(data_t x);
    return x[DataW-1] ? (~x + data_t'(1)) : x;
  endfunction

  // euclid on the magnitudes, unsigned so the most negative operand is exact
  function automatic gcd_result_t gcd_of_magnitudes(data_t a, data_t b);
    gcd_result_t res;
    data_t x;
    data_t y;
    data_t rem;
    x = magnitude_of(a);
    y = magnitude_of(b);
    while (y != '0) begin
      rem = x % y;
      x = y;
      y = rem;
    end
    res.divisor = x;
    res.coprime = (x == data_t'(1));
    return res;
  endfunction

  function automatic data_t rand_bits(int unsigned w);
    data_t r;
    r = {$urandom, $urandom};
    if (w >= DataW) begin
      return r;
    end
    return r & ((data_t'(1) << w) - data_t'(1));
  endfunction

  function automatic data_t maybe_negate(data_t x);
    return ($urandom_range(0, 1) != 0) ? (~x + data_t'(1)) : x;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, data_t got, data_t want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // called at a falling edge; returns at a falling edge with valid low or kept high
  task automatic send_pair(data_t a, data_t b);
    int unsigned gap;
    gcd_in.valid   <= 1'b1;
    gcd_in.value_a <= a;
    gcd_in.value_b <= b;
    do @(posedge clk); while (!gcd_in.ready);
    expected_gcd_q.push_back(gcd_of_magnitudes(a, b));
    pairs_sent++;
    @(negedge clk);
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      gcd_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    gcd_in.valid <= 1'b0;
    while (expected_gcd_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    gcd_result_t want;
    if (rst_n && gcd_out.valid && gcd_out.ready) begin
      if (expected_gcd_q.size() == 0) begin
        report_mismatch("unexpected item", gcd_out.divisor, '0);
      end else begin
        want = expected_gcd_q.pop_front();
        results_seen++;
        if (gcd_out.coprime) coprime_seen++;
        if (gcd_out.divisor == '0) zero_seen++;
        if (gcd_out.divisor !== want.divisor) begin
          report_mismatch("divisor", gcd_out.divisor, want.divisor);
        end
        if (gcd_out.coprime !== want.coprime) begin
          report_mismatch("coprime", data_t'(gcd_out.coprime), data_t'(want.coprime));
        end
      end
    end
  end

  // receiver with random stalls
  initial begin
    gcd_out.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        gcd_out.ready <= 1'b1;
      end else if (stall_left != 0) begin
        gcd_out.ready <= 1'b0;
        stall_left--;
      end else begin
        gcd_out.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic test_special_cases();
    send_pair('0, '0);
    send_pair('0, data_t'(5));
    send_pair(data_t'(5), '0);
    send_pair(MostNeg, '0);
    send_pair('0, MostNeg);
    send_pair(MostNeg, MostNeg);
    send_pair(MostNeg, MostPos);
    send_pair(MostPos, MostPos);
    send_pair(MostPos, data_t'(1));
    send_pair(data_t'(1), data_t'(1));
    send_pair('1, '1);
    send_pair('1, '0);
    send_pair(MostNeg, data_t'(-(64'sd1 <<< 62)));
    send_pair(data_t'(12), data_t'(-64'sd18));
    send_pair(data_t'(-64'sd12), data_t'(18));
    send_pair(data_t'(-64'sd7), data_t'(-64'sd13));
    send_pair(MostPos, MostPos - data_t'(1));
    send_pair(MostNeg + data_t'(1), MostNeg);
    send_pair('1, MostNeg);
    send_pair({32'hffff_ffff, 32'h0}, {32'h0, 32'hffff_ffff});
    send_pair(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
  endtask

  // consecutive fibonacci numbers give the longest remainder chains, then pairs of powers of two
  task automatic test_long_chains();
    data_t fib[0:92];
    int unsigned k;
    int unsigned s;
    int unsigned t;
    fib[0] = '0;
    fib[1] = data_t'(1);
    for (int i = 2; i <= 92; i++) fib[i] = fib[i-1] + fib[i-2];
    for (int i = 0; i < 8; i++) begin
      k = (i < 2) ? 92 - i : $urandom_range(3, 92);
      send_pair(maybe_negate(fib[k]), maybe_negate(fib[k-1]));
    end
    for (int i = 0; i < 8; i++) begin
      s = $urandom_range(0, 62);
      t = $urandom_range(0, 63);
      send_pair(maybe_negate(data_t'(1) << s), data_t'(1) << t);
    end
  endtask

  // sender holds off until the block has returned everything
  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) begin
      send_pair(maybe_negate(rand_bits(40)), maybe_negate(rand_bits(40)));
    end
    wait_all_results();
    for (int i = 0; i < 6; i++) begin
      send_pair(maybe_negate(rand_bits(20)), rand_bits(64));
    end
    wait_all_results();
  endtask

  task automatic test_random_mix(int unsigned count);
    data_t a;
    data_t b;
    data_t g;
    int unsigned gw;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n == count / 2) wait_all_results();
      case ($urandom_range(0, 9))
        0, 1: begin
          a = rand_bits(64);
          b = rand_bits(64);
        end
        2, 3: begin
          gw = $urandom_range(1, 30);
          g = rand_bits(gw);
          a = maybe_negate(g * rand_bits($urandom_range(1, 62 - gw)));
          b = maybe_negate(g * rand_bits($urandom_range(1, 62 - gw)));
        end
        4: begin
          a = maybe_negate(data_t'($urandom_range(0, 1000)));
          b = maybe_negate(data_t'($urandom_range(0, 1000)));
        end
        5: begin
          a = ($urandom_range(0, 3) == 0) ? MostNeg : rand_bits(64);
          b = '0;
          if ($urandom_range(0, 1) != 0) begin
            b = a;
            a = '0;
          end
        end
        6: begin
          a = maybe_negate(rand_bits($urandom_range(1, 20)) << $urandom_range(0, 40));
          b = maybe_negate(rand_bits($urandom_range(1, 20)) << $urandom_range(0, 40));
        end
        7: begin
          a = rand_bits(64);
          b = maybe_negate(a);
        end
        8: begin
          a = MostNeg;
          b = ($urandom_range(0, 1) != 0) ? rand_bits(64) >> $urandom_range(0, 63)
                                          : data_t'(1) << $urandom_range(0, 63);
        end
        default: begin
          a = maybe_negate(rand_bits($urandom_range(1, 64)));
          b = maybe_negate(rand_bits($urandom_range(1, 64)));
        end
      endcase
      send_pair(a, b);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    error_count  = 0;
    pairs_sent   = 0;
    results_seen = 0;
    coprime_seen = 0;
    zero_seen    = 0;
    idle_on      = 1'b1;
    rst_n          = 1'b0;
    gcd_in.valid   = 1'b0;
    gcd_in.value_a = '0;
    gcd_in.value_b = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_special_cases();
    test_long_chains();
    test_drain_pause();
    test_random_mix(600);

    wait_all_results();
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d operand pairs, checked %0d results", pairs_sent, results_seen);
    $display("results with coprime set: %0d, with zero divisor: %0d", coprime_seen, zero_seen);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- euclid_gcd_coprime.f -----
hw/rtl/egc_pkg.sv
hw/rtl/egc_if.sv
hw/rtl/euclid_gcd_coprime.sv
tb/sv/testbench.sv
